>>> rtl/core/kmst_pkg.sv
// ----------------------------------------------------------------------------
// kmst_pkg
// Shared types and constants for the minimum spanning tree block.
// ----------------------------------------------------------------------------
package kmst_pkg;

   localparam int NODE_W  = 7;
   localparam int COST_W  = 16;
   localparam int TOTAL_W = 22;
   localparam logic [NODE_W-1:0] NODE_COUNT_RST = 7'd64;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_PASS,
      ST_SCAN,
      ST_SCAN_END,
      ST_DECIDE,
      ST_FIND_A_RD,
      ST_FIND_A_CHK,
      ST_FIND_B_RD,
      ST_FIND_B_CHK,
      ST_RANK_U,
      ST_RANK_V,
      ST_JOIN,
      ST_EMIT,
      ST_FINAL
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic run_start;
      logic clr_step;
      logic pass_start;
      logic scan_rd;
      logic take_best;
      logic find_step;
      logic find_a_done;
      logic find_b_done;
      logic rank_u;
      logic rank_v;
      logic join_roots;
      logic emit;
      logic final_out;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic load_last;
      logic clr_done;
      logic scan_done;
      logic empty;
      logic sel_done;
      logic have_best;
      logic par_root;
      logic same_root;
      logic emit_ok;
      logic out_free;
   } status_type;

endpackage

>>> rtl/core/kmst_if.sv
// ----------------------------------------------------------------------------
// kmst channel interfaces
// Edge input, tree result and configuration write channels.
// ----------------------------------------------------------------------------
interface kmst_req_if;
   logic                        valid;
   logic                        ready;
   logic [kmst_pkg::NODE_W-1:0] edge_from;
   logic [kmst_pkg::NODE_W-1:0] edge_to;
   logic [kmst_pkg::COST_W-1:0] edge_cost;
   logic                        last_edge;
   modport source (output valid, edge_from, edge_to, edge_cost, last_edge, input ready);
   modport sink (input valid, edge_from, edge_to, edge_cost, last_edge, output ready);
endinterface

interface kmst_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         edge_valid;
   logic [kmst_pkg::NODE_W-1:0]  tree_from;
   logic [kmst_pkg::NODE_W-1:0]  tree_to;
   logic [kmst_pkg::COST_W-1:0]  tree_cost;
   logic [kmst_pkg::TOTAL_W-1:0] running_total;
   logic                         input_dropped;
   logic                         last_result;
   modport source (output valid, edge_valid, tree_from, tree_to, tree_cost,
                   running_total, input_dropped, last_result, input ready);
   modport sink (input valid, edge_valid, tree_from, tree_to, tree_cost,
                 running_total, input_dropped, last_result, output ready);
endinterface

interface kmst_csr_if;
   logic                        valid;
   logic                        ready;
   logic [kmst_pkg::NODE_W-1:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

>>> rtl/core/kmst_ram.sv
// ----------------------------------------------------------------------------
// kmst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kmst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                        wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                        rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

>>> rtl/core/kmst_ctrl.sv
// ----------------------------------------------------------------------------
// kmst_ctrl
// Sequencer for load, union-find clear, selection scans, find, join, emit.
// ----------------------------------------------------------------------------
module kmst_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  kmst_pkg::status_type st,
   output kmst_pkg::cmd_type    cmd
);
   import kmst_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:       if (st.load_last) state_in = ST_CLEAR;
         ST_CLEAR:      if (st.clr_done) state_in = ST_PASS;
         ST_PASS:       state_in = (st.empty || st.sel_done) ? ST_FINAL : ST_SCAN;
         ST_SCAN:       if (st.scan_done) state_in = ST_SCAN_END;
         ST_SCAN_END:   state_in = ST_DECIDE;
         ST_DECIDE:     state_in = st.have_best ? ST_FIND_A_RD : ST_FINAL;
         ST_FIND_A_RD:  state_in = ST_FIND_A_CHK;
         ST_FIND_A_CHK: state_in = st.par_root ? ST_FIND_B_RD : ST_FIND_A_RD;
         ST_FIND_B_RD:  state_in = ST_FIND_B_CHK;
         ST_FIND_B_CHK: begin
            if (!st.par_root) begin
               state_in = ST_FIND_B_RD;
            end else begin
               state_in = st.same_root ? ST_PASS : ST_RANK_U;
            end
         end
         ST_RANK_U:     state_in = ST_RANK_V;
         ST_RANK_V:     state_in = ST_JOIN;
         ST_JOIN:       state_in = ST_EMIT;
         ST_EMIT:       if (st.emit_ok) state_in = ST_PASS;
         ST_FINAL:      if (st.out_free) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load      = 1'b1;
            cmd.run_start = st.load_last;
         end
         ST_CLEAR:      cmd.clr_step = 1'b1;
         ST_PASS:       cmd.pass_start = 1'b1;
         ST_SCAN:       cmd.scan_rd = 1'b1;
         ST_DECIDE:     cmd.take_best = st.have_best;
         ST_FIND_A_CHK: begin
            cmd.find_a_done = st.par_root;
            cmd.find_step   = !st.par_root;
         end
         ST_FIND_B_CHK: begin
            cmd.find_b_done = st.par_root;
            cmd.find_step   = !st.par_root;
         end
         ST_RANK_U:     cmd.rank_u = 1'b1;
         ST_RANK_V:     cmd.rank_v = 1'b1;
         ST_JOIN:       cmd.join_roots = 1'b1;
         ST_EMIT:       cmd.emit = st.emit_ok;
         ST_FINAL:      cmd.final_out = st.out_free;
         default:       cmd = '0;
      endcase
   end
endmodule

>>> rtl/core/kmst_dp.sv
// ----------------------------------------------------------------------------
// kmst_dp
// Edge store, selection scan, union-find tables and result registers.
// ----------------------------------------------------------------------------
module kmst_dp #(
   parameter int MAX_NODES = 64,
   parameter int MAX_EDGES = 1024,
   parameter int COST_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   kmst_req_if.sink             req_bus,
   kmst_rsp_if.source           rsp_bus,
   kmst_csr_if.sink             csr_bus,
   input  kmst_pkg::cmd_type    cmd,
   output kmst_pkg::status_type st
);
   import kmst_pkg::*;

   localparam int NW    = $clog2(MAX_NODES);
   localparam int AW    = MAX_EDGES > 1 ? $clog2(MAX_EDGES) : 1;
   localparam int CNT_W = $clog2(MAX_EDGES + 1);
   localparam int EW    = 2 * NW + COST_W;
   localparam int KW    = COST_W + AW;
   localparam int RK_W  = 3;
   localparam logic [COST_W-1:0] COST_MASK =
      COST_BITS >= COST_W ? {COST_W{1'b1}} : COST_W'((64'd1 << COST_BITS) - 64'd1);

   // configuration
   logic [NODE_W-1:0] node_count_ff;
   logic [NODE_W-1:0] eff_n;
   assign csr_bus.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RST;
      end else if (csr_bus.valid) begin
         node_count_ff <= csr_bus.data;
      end
   end
   assign eff_n = (node_count_ff > NODE_W'(MAX_NODES)) ? NODE_W'(MAX_NODES) : node_count_ff;

   // edge load
   logic [CNT_W-1:0]  count_ff;
   logic              dropped_ff;
   logic [NODE_W-1:0] limit_ff;
   logic              accept, in_range, full, e_we;
   logic [EW-1:0]     e_wdata, e_rdata;
   logic [AW-1:0]     scan_ff;

   assign req_bus.ready = cmd.load;
   assign accept   = cmd.load && req_bus.valid;
   assign in_range = (req_bus.edge_from != '0) && (req_bus.edge_from <= eff_n) &&
                     (req_bus.edge_to != '0) && (req_bus.edge_to <= eff_n);
   assign full     = (count_ff == CNT_W'(MAX_EDGES));
   assign e_we     = accept && in_range && !full;
   assign e_wdata  = {NW'(req_bus.edge_from - 7'd1), NW'(req_bus.edge_to - 7'd1),
                      req_bus.edge_cost & COST_MASK};

   kmst_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edge_ram (
      .clock (clock),
      .we    (e_we),
      .waddr (count_ff[AW-1:0]),
      .wdata (e_wdata),
      .raddr (scan_ff),
      .rdata (e_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else if (cmd.final_out) begin
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else if (accept) begin
         if (e_we) begin
            count_ff <= count_ff + 1'b1;
         end else begin
            dropped_ff <= 1'b1;
         end
      end
   end

   // selection scan: next edge in (cost, arrival) order after the previous key
   logic          rd_vld_ff, have_prev_ff, best_vld_ff;
   logic [AW-1:0] rd_idx_ff;
   logic [KW-1:0] prev_key_ff, best_key_ff, cand_key;
   logic [NW-1:0] best_a_ff, best_b_ff;
   logic          cand_ok;

   assign cand_key = {e_rdata[COST_W-1:0], rd_idx_ff};
   assign cand_ok  = rd_vld_ff && (!have_prev_ff || cand_key > prev_key_ff) &&
                     (!best_vld_ff || cand_key < best_key_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff    <= 1'b0;
         have_prev_ff <= 1'b0;
         best_vld_ff  <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.scan_rd;
         if (cmd.run_start) begin
            have_prev_ff <= 1'b0;
         end else if (cmd.take_best) begin
            have_prev_ff <= 1'b1;
         end
         if (cmd.pass_start) begin
            best_vld_ff <= 1'b0;
         end else if (cand_ok) begin
            best_vld_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pass_start) begin
         scan_ff <= '0;
      end else if (cmd.scan_rd) begin
         scan_ff <= scan_ff + 1'b1;
      end
      rd_idx_ff <= scan_ff;
      if (cand_ok) begin
         best_key_ff <= cand_key;
         best_a_ff   <= e_rdata[EW-1 -: NW];
         best_b_ff   <= e_rdata[COST_W +: NW];
      end
      if (cmd.take_best) begin
         prev_key_ff <= best_key_ff;
      end
   end

   // union-find tables
   logic [NW-1:0]   clr_ff, x_ff, ru_ff, rv_ff;
   logic [NW-1:0]   p_rdata, p_waddr, p_wdata;
   logic [RK_W-1:0] rk_rdata, rk_u_ff, rk_wdata;
   logic [NW-1:0]   rk_waddr, rk_raddr;
   logic            p_we, rk_we, u_low, rk_eq;

   assign u_low    = rk_u_ff < rk_rdata;
   assign rk_eq    = rk_u_ff == rk_rdata;
   assign p_we     = cmd.clr_step || cmd.join_roots;
   assign p_waddr  = cmd.clr_step ? clr_ff : (u_low ? ru_ff : rv_ff);
   assign p_wdata  = cmd.clr_step ? clr_ff : (u_low ? rv_ff : ru_ff);
   assign rk_we    = cmd.clr_step || (cmd.join_roots && rk_eq);
   assign rk_waddr = cmd.clr_step ? clr_ff : ru_ff;
   assign rk_wdata = cmd.clr_step ? '0 : rk_u_ff + 1'b1;
   assign rk_raddr = cmd.rank_u ? ru_ff : rv_ff;

   kmst_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_parent_ram (
      .clock (clock),
      .we    (p_we),
      .waddr (p_waddr),
      .wdata (p_wdata),
      .raddr (x_ff),
      .rdata (p_rdata)
   );

   kmst_ram #(.WIDTH(RK_W), .DEPTH(MAX_NODES)) u_rank_ram (
      .clock (clock),
      .we    (rk_we),
      .waddr (rk_waddr),
      .wdata (rk_wdata),
      .raddr (rk_raddr),
      .rdata (rk_rdata)
   );

   always_ff @(posedge clock) begin
      if (cmd.run_start) begin
         clr_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_ff <= clr_ff + 1'b1;
      end
      // walk parent links to the root
      if (cmd.take_best) begin
         x_ff <= best_a_ff;
      end else if (cmd.find_step) begin
         x_ff <= p_rdata;
      end else if (cmd.find_a_done) begin
         x_ff <= best_b_ff;
      end
      if (cmd.find_a_done) begin
         ru_ff <= x_ff;
      end
      if (cmd.find_b_done) begin
         rv_ff <= x_ff;
      end
      if (cmd.rank_v) begin
         rk_u_ff <= rk_rdata;
      end
   end

   // selection count and running total
   logic [NODE_W-1:0]  sel_ff;
   logic [TOTAL_W-1:0] total_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= '0;
      end else if (cmd.run_start) begin
         sel_ff <= '0;
      end else if (cmd.join_roots) begin
         sel_ff <= sel_ff + 1'b1;
      end
   end
   always_ff @(posedge clock) begin
      if (cmd.run_start) begin
         total_ff <= '0;
         limit_ff <= (eff_n == '0) ? '0 : eff_n - 1'b1;
      end else if (cmd.join_roots) begin
         total_ff <= total_ff + TOTAL_W'(best_key_ff[KW-1 -: COST_W]);
      end
   end

   // pending result and output register
   logic               pend_vld_ff, out_vld_ff, out_free;
   logic [NW-1:0]      pend_a_ff, pend_b_ff;
   logic [COST_W-1:0]  pend_w_ff;
   logic [TOTAL_W-1:0] pend_t_ff;
   logic               o_ev_ff, o_drop_ff, o_last_ff;
   logic [NODE_W-1:0]  o_from_ff, o_to_ff;
   logic [COST_W-1:0]  o_cost_ff;
   logic [TOTAL_W-1:0] o_tot_ff;
   logic               push_pend;

   assign out_free  = !out_vld_ff || rsp_bus.ready;
   assign push_pend = (cmd.emit && pend_vld_ff) || cmd.final_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         if (cmd.run_start || cmd.final_out) begin
            pend_vld_ff <= 1'b0;
         end else if (cmd.emit) begin
            pend_vld_ff <= 1'b1;
         end
         if (push_pend) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         pend_a_ff <= best_a_ff;
         pend_b_ff <= best_b_ff;
         pend_w_ff <= best_key_ff[KW-1 -: COST_W];
         pend_t_ff <= total_ff;
      end
      if (push_pend) begin
         o_ev_ff   <= pend_vld_ff;
         o_from_ff <= pend_vld_ff ? NODE_W'(pend_a_ff) + 1'b1 : '0;
         o_to_ff   <= pend_vld_ff ? NODE_W'(pend_b_ff) + 1'b1 : '0;
         o_cost_ff <= pend_vld_ff ? pend_w_ff : '0;
         o_tot_ff  <= pend_vld_ff ? pend_t_ff : '0;
         o_drop_ff <= dropped_ff;
         o_last_ff <= cmd.final_out;
      end
   end

   assign rsp_bus.valid         = out_vld_ff;
   assign rsp_bus.edge_valid    = o_ev_ff;
   assign rsp_bus.tree_from     = o_from_ff;
   assign rsp_bus.tree_to       = o_to_ff;
   assign rsp_bus.tree_cost     = o_cost_ff;
   assign rsp_bus.running_total = o_tot_ff;
   assign rsp_bus.input_dropped = o_drop_ff;
   assign rsp_bus.last_result   = o_last_ff;

   // status
   assign st.load_last = accept && req_bus.last_edge;
   assign st.clr_done  = clr_ff == NW'(MAX_NODES - 1);
   assign st.scan_done = scan_ff == AW'(count_ff - 1'b1);
   assign st.empty     = count_ff == '0;
   assign st.sel_done  = sel_ff >= limit_ff;
   assign st.have_best = best_vld_ff;
   assign st.par_root  = p_rdata == x_ff;
   assign st.same_root = ru_ff == x_ff;
   assign st.emit_ok   = !pend_vld_ff || out_free;
   assign st.out_free  = out_free;
endmodule

>>> rtl/core/kruskal_min_spanning_tree_top.sv
// ----------------------------------------------------------------------------
// kruskal_min_spanning_tree_top
// Minimum spanning tree of a loaded edge list, union-find with union by rank.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one edge per transaction; one edge is taken per cycle while
//   the block is idle. Edges with an endpoint out of 1..min(node_count,
//   MAX_NODES), or beyond the store capacity, are dropped and flagged on every
//   result of the graph. The transaction with last_edge set starts the run;
//   req_bus.ready stays low until its final result has been loaded into the
//   output register. A run clears the union-find tables, then repeats a scan
//   of the edge store (one store read port) to find the next edge in
//   cost/arrival order, then walks parent links and, if the two roots differ,
//   reads two ranks, joins and emits. Up to edge count + 1 scans per run.
//   rsp_bus gives each tree edge with its running total; the final one has
//   last_result set, or a single empty result if no edge was selected. One
//   result is held back to mark the last one; a stalled receiver stops the run.
//   csr_bus writes node_count (reset 64); write only while idle.
//   Reset (synchronous) empties the edge store and clears the drop flag.
// ----------------------------------------------------------------------------
module kruskal_min_spanning_tree_top #(
   parameter int MAX_NODES = 64,
   parameter int MAX_EDGES = 1024,
   parameter int COST_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   kmst_req_if.sink   req_bus,
   kmst_rsp_if.source rsp_bus,
   kmst_csr_if.sink   csr_bus
);
   import kmst_pkg::*;

   cmd_type    cmd;
   status_type st;

   kmst_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .st    (st),
      .cmd   (cmd)
   );

   kmst_dp #(
      .MAX_NODES (MAX_NODES),
      .MAX_EDGES (MAX_EDGES),
      .COST_BITS (COST_BITS)
   ) u_dp (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus),
      .cmd     (cmd),
      .st      (st)
   );
endmodule

>>> rtl/core/kmst_checker.sv
// ----------------------------------------------------------------------------
// kmst_checker
// Port-level checks on the result channel of the spanning tree block.
// ----------------------------------------------------------------------------
module kmst_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        edge_valid,
   input logic                        last_result,
   input logic [kmst_pkg::NODE_W-1:0] tree_from,
   input logic [kmst_pkg::NODE_W-1:0] tree_to
);
   // a waiting result is not withdrawn
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn while stalled");

   // nothing is offered right after reset
   a_rst: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // an empty result closes the run
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !edge_valid |-> last_result)
      else $error("empty result not marked last");

   // a tree edge names real nodes
   a_nodes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && edge_valid |-> (tree_from != '0) && (tree_to != '0))
      else $error("tree edge with node zero");
endmodule

bind kruskal_min_spanning_tree_top kmst_checker u_kmst_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .edge_valid  (rsp_bus.edge_valid),
   .last_result (rsp_bus.last_result),
   .tree_from   (rsp_bus.tree_from),
   .tree_to     (rsp_bus.tree_to)
);
